// File: rtl/core/dts_pkg.sv
// Shared widths, codes and controller/datapath interface types of the DAC trim search core.
package dts_pkg;

    // Converter and search constants
    localparam int ADC_BITS       = 12;
    localparam int FRAC_BITS      = 4;
    localparam int DAC_MAX        = 31;
    localparam int MAX_ITERATIONS = 32;
    localparam int START_RESET    = 15;

    localparam int CODE_W = 5;
    localparam int ITER_W = 6;
    localparam int TAG_W  = 16;

    // Fixed-point level: ADC code with fraction bits, plus the 16-bit target offset
    localparam int LVL_W  = ADC_BITS + FRAC_BITS + 1;
    // Distance times DAC_MAX, then doubled plus the half divisor
    localparam int MUL_W  = LVL_W + CODE_W;
    localparam int NUM_W  = MUL_W + 2;
    // Doubled divisor: lsb span with fraction bits, times two
    localparam int DEN_W  = ADC_BITS + FRAC_BITS + 1;
    // Quotient bits needed to tell a step count above DAC_MAX + 1
    localparam int Q_W    = $clog2(DAC_MAX + 2);
    localparam int DCNT_W = $clog2(Q_W + 1);

    // Port widths
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_START  = 2'd1,
        CFG_INVERT = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_START  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_GND    = 4'd1,
        PH_LO     = 4'd2,
        PH_HI     = 4'd3,
        PH_START  = 4'd4,
        PH_CENTER = 4'd5,
        PH_DOWN   = 4'd6,
        PH_UP     = 4'd7
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_EXEC   = 4'd1,
        ST_PREP   = 4'd2,
        ST_DIV    = 4'd3,
        ST_EXTRAP = 4'd4,
        ST_STORE  = 4'd5,
        ST_HILL   = 4'd6,
        ST_CHECK  = 4'd7,
        ST_EMIT   = 4'd8
    } ctl_state_t;

    typedef enum logic [3:0] {
        RES_START  = 4'd0,
        RES_LO     = 4'd1,
        RES_HI     = 4'd2,
        RES_SEED   = 4'd3,
        RES_CENTER = 4'd4,
        RES_DOWN   = 4'd5,
        RES_UP     = 4'd6,
        RES_FINAL  = 4'd7,
        RES_LIMIT  = 4'd8
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     clear_iter;
        logic     cap_ground;
        logic     cap_offset;
        logic     cap_lsb;
        logic     dist_en;
        logic     div_load;
        logic     div_step;
        logic     set_extrap;
        logic     cap_center;
        logic     cap_down;
        logic     hill_move;
        logic     out_load;
        res_sel_t res_sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic any_better;
        logic iter_limit;
        logic out_free;
    } ctl_status_t;

endpackage

// File: rtl/core/dts_datapath.sv
// Datapath of the DAC trim search core: config, readings, distance, divider, output register.
module dts_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [dts_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dts_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    input  dts_pkg::ctl_cmd_t               cmd,
    output dts_pkg::ctl_status_t            status
);

    // Configuration and control-side registers
    logic [dts_pkg::TAG_W-1:0]   tag_reg;
    logic [dts_pkg::CODE_W-1:0]  start_reg;
    logic                        inv_reg;
    logic [dts_pkg::ITER_W-1:0]  iter_reg;
    logic                        m_tvalid_reg;

    // Payload registers
    logic [dts_pkg::ADC_BITS-1:0] adc_reg;
    logic [dts_pkg::ADC_BITS-1:0] off_reg;
    logic [dts_pkg::ADC_BITS-1:0] lsb_reg;
    logic [dts_pkg::LVL_W-1:0]    tl_reg;
    logic [dts_pkg::LVL_W-1:0]    dist_reg;
    logic                         below_reg;
    logic [dts_pkg::LVL_W-1:0]    dc_reg;
    logic [dts_pkg::LVL_W-1:0]    dd_reg;
    logic [dts_pkg::CODE_W-1:0]   center_reg;
    logic [dts_pkg::NUM_W-1:0]    rem_reg;
    logic [dts_pkg::NUM_W-1:0]    dsh_reg;
    logic [dts_pkg::Q_W:0]        q_reg;
    logic [dts_pkg::DCNT_W-1:0]   dcnt_reg;
    logic [dts_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                         m_tuser_reg;

    // Combinational values
    logic [dts_pkg::LVL_W:0]      adc_lvl;
    logic [dts_pkg::LVL_W:0]      diff;
    logic [dts_pkg::LVL_W:0]      diff_neg;
    logic [dts_pkg::LVL_W-1:0]    dist_next;
    logic [dts_pkg::LVL_W-1:0]    tl_next;
    logic [dts_pkg::ADC_BITS-1:0] lsb_next;
    logic [dts_pkg::MUL_W-1:0]    mul;
    logic [dts_pkg::DEN_W-1:0]    dvs;
    logic [dts_pkg::NUM_W-1:0]    num_next;
    logic                         rem_ge;
    logic [dts_pkg::Q_W-1:0]      steps;
    logic [dts_pkg::CODE_W-1:0]   start_clamp;
    logic [dts_pkg::Q_W:0]        start_ext;
    logic [dts_pkg::Q_W:0]        steps_ext;
    logic [dts_pkg::Q_W:0]        sum_ext;
    logic [dts_pkg::Q_W:0]        code_ext;
    logic [dts_pkg::CODE_W-1:0]   extrap_code;
    logic [dts_pkg::CODE_W-1:0]   up_code;
    logic [dts_pkg::CODE_W-1:0]   down_code;
    logic                         down_better;
    logic                         up_better;
    logic                         up_wins;
    logic                         zero_lsb;
    logic                         out_wr;
    logic [dts_pkg::CODE_W-1:0]   out_code;
    logic                         out_ch;
    logic                         out_done;
    logic [dts_pkg::CODE_W-1:0]   out_fin;
    logic                         out_lim;

    // Distance of the captured reading from the target level
    always_comb begin
        adc_lvl   = (dts_pkg::LVL_W + 1)'(adc_reg) << dts_pkg::FRAC_BITS;
        diff      = {1'b0, tl_reg} - adc_lvl;
        diff_neg  = ~diff + 1'b1;
        dist_next = diff[dts_pkg::LVL_W] ? diff_neg[dts_pkg::LVL_W-1:0]
                                         : diff[dts_pkg::LVL_W-1:0];
        tl_next   = adc_lvl[dts_pkg::LVL_W-1:0] + dts_pkg::LVL_W'(tag_reg);
        lsb_next  = (adc_reg >= off_reg) ? (adc_reg - off_reg) : (off_reg - adc_reg);
    end

    // Divider operands: (2 * dist * DAC_MAX + den) / (2 * den)
    always_comb begin
        mul      = dts_pkg::MUL_W'(dist_reg) * dts_pkg::MUL_W'(dts_pkg::DAC_MAX);
        dvs      = dts_pkg::DEN_W'(lsb_reg) << (dts_pkg::FRAC_BITS + 1);
        num_next = (dts_pkg::NUM_W'(mul) << 1) + dts_pkg::NUM_W'(dvs >> 1);
        rem_ge   = rem_reg >= dsh_reg;
    end

    // Extrapolated code from the saturated step count
    always_comb begin
        zero_lsb = (lsb_reg == '0);
        if (zero_lsb) begin
            steps = '0;
        end else if (q_reg[dts_pkg::Q_W] ||
                     (q_reg[dts_pkg::Q_W-1:0] > dts_pkg::Q_W'(dts_pkg::DAC_MAX + 1))) begin
            steps = dts_pkg::Q_W'(dts_pkg::DAC_MAX + 1);
        end else begin
            steps = q_reg[dts_pkg::Q_W-1:0];
        end
        start_clamp = (start_reg > dts_pkg::CODE_W'(dts_pkg::DAC_MAX))
                      ? dts_pkg::CODE_W'(dts_pkg::DAC_MAX) : start_reg;
        start_ext = (dts_pkg::Q_W + 1)'(start_clamp);
        steps_ext = (dts_pkg::Q_W + 1)'(steps);
        sum_ext   = start_ext + steps_ext;
        if (below_reg ^ inv_reg) begin
            code_ext = (steps_ext > start_ext) ? '0 : (start_ext - steps_ext);
        end else begin
            code_ext = (sum_ext > (dts_pkg::Q_W + 1)'(dts_pkg::DAC_MAX))
                       ? (dts_pkg::Q_W + 1)'(dts_pkg::DAC_MAX) : sum_ext;
        end
        extrap_code = code_ext[dts_pkg::CODE_W-1:0];
    end

    // Neighbor codes and hill-climb comparisons
    always_comb begin
        up_code     = (center_reg >= dts_pkg::CODE_W'(dts_pkg::DAC_MAX))
                      ? dts_pkg::CODE_W'(dts_pkg::DAC_MAX) : center_reg + 1'b1;
        down_code   = (center_reg == '0) ? '0 : center_reg - 1'b1;
        down_better = dd_reg < dc_reg;
        up_better   = dist_reg < dc_reg;
        up_wins     = up_better && (!down_better || (dist_reg <= dd_reg));
    end

    // Result fields by kind
    always_comb begin
        out_wr   = 1'b1;
        out_code = '0;
        out_ch   = 1'b1;
        out_done = 1'b0;
        out_fin  = '0;
        out_lim  = 1'b0;
        case (cmd.res_sel)
            dts_pkg::RES_START: begin
                out_wr = 1'b0;
                out_ch = 1'b0;
            end
            dts_pkg::RES_LO: begin
                out_code = '0;
            end
            dts_pkg::RES_HI: begin
                out_code = dts_pkg::CODE_W'(dts_pkg::DAC_MAX);
            end
            dts_pkg::RES_SEED: begin
                out_code = start_clamp;
            end
            dts_pkg::RES_CENTER: begin
                out_code = center_reg;
            end
            dts_pkg::RES_DOWN: begin
                out_code = down_code;
            end
            dts_pkg::RES_UP: begin
                out_code = up_code;
            end
            dts_pkg::RES_FINAL: begin
                out_code = center_reg;
                out_ch   = 1'b0;
                out_done = 1'b1;
                out_fin  = center_reg;
                out_lim  = zero_lsb;
            end
            dts_pkg::RES_LIMIT: begin
                out_code = center_reg;
                out_ch   = 1'b0;
                out_done = 1'b1;
                out_fin  = center_reg;
                out_lim  = 1'b1;
            end
            default: begin
                out_wr = 1'b0;
                out_ch = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg      <= '0;
            start_reg    <= dts_pkg::CODE_W'(dts_pkg::START_RESET);
            inv_reg      <= 1'b0;
            iter_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    dts_pkg::CFG_TARGET: tag_reg   <= cfg_wdata[dts_pkg::TAG_W-1:0];
                    dts_pkg::CFG_START:  start_reg <= cfg_wdata[dts_pkg::CODE_W-1:0];
                    dts_pkg::CFG_INVERT: inv_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.clear_iter) begin
                iter_reg <= '0;
            end else if (cmd.hill_move) begin
                iter_reg <= iter_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            adc_reg <= s_tdata[dts_pkg::ADC_BITS-1:0];
        end
        if (cmd.cap_ground) begin
            tl_reg <= tl_next;
        end
        if (cmd.cap_offset) begin
            off_reg <= adc_reg;
        end
        if (cmd.cap_lsb) begin
            lsb_reg <= lsb_next;
        end
        if (cmd.dist_en) begin
            dist_reg  <= dist_next;
            below_reg <= diff[dts_pkg::LVL_W];
        end
        if (cmd.div_load) begin
            rem_reg  <= num_next;
            dsh_reg  <= dts_pkg::NUM_W'(dvs) << dts_pkg::Q_W;
            q_reg    <= '0;
            dcnt_reg <= dts_pkg::DCNT_W'(dts_pkg::Q_W);
        end else if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg    <= {q_reg[dts_pkg::Q_W-1:0], rem_ge};
            dsh_reg  <= dsh_reg >> 1;
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.set_extrap) begin
            center_reg <= extrap_code;
        end else if (cmd.hill_move) begin
            center_reg <= up_wins ? up_code : down_code;
        end
        if (cmd.cap_center) begin
            dc_reg <= dist_reg;
        end
        if (cmd.cap_down) begin
            dd_reg <= dist_reg;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= dts_pkg::M_TDATA_W'({out_lim, out_fin, out_ch, out_code, out_wr});
            m_tuser_reg <= out_done;
        end
    end

    assign status.div_last   = (dcnt_reg == '0);
    assign status.any_better = down_better || up_better;
    assign status.iter_limit = (iter_reg >= dts_pkg::ITER_W'(dts_pkg::MAX_ITERATIONS));
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // A new result never replaces one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while pending");

    // The search ends before the iteration count passes its limit
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg <= dts_pkg::ITER_W'(dts_pkg::MAX_ITERATIONS))
        else $error("iteration count beyond limit");

    // A loaded result is presented on the next cycle
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");
`endif

endmodule

// File: rtl/core/dts_ctrl.sv
// Controller of the DAC trim search core: search phase and per-transaction sequencing.
module dts_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,
    output dts_pkg::ctl_cmd_t     cmd,
    input  dts_pkg::ctl_status_t  status
);

    dts_pkg::ctl_state_t state_reg, state_next;
    dts_pkg::phase_t     phase_reg, phase_next;
    dts_pkg::res_sel_t   res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dts_pkg::ST_IDLE;
            phase_reg <= dts_pkg::PH_IDLE;
            res_reg   <= dts_pkg::RES_START;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            res_reg   <= res_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        res_next    = res_reg;
        cmd         = '0;
        cmd.res_sel = res_reg;
        s_tready    = 1'b0;
        case (state_reg)
            dts_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    if (s_tuser == dts_pkg::OP_START) begin
                        cmd.clear_iter = 1'b1;
                        phase_next     = dts_pkg::PH_GND;
                        res_next       = dts_pkg::RES_START;
                        state_next     = dts_pkg::ST_EMIT;
                    end else if (phase_reg != dts_pkg::PH_IDLE) begin
                        state_next = dts_pkg::ST_EXEC;
                    end
                end
            end
            dts_pkg::ST_EXEC: begin
                case (phase_reg)
                    dts_pkg::PH_GND: begin
                        cmd.cap_ground = 1'b1;
                        phase_next     = dts_pkg::PH_LO;
                        res_next       = dts_pkg::RES_LO;
                        state_next     = dts_pkg::ST_EMIT;
                    end
                    dts_pkg::PH_LO: begin
                        cmd.cap_offset = 1'b1;
                        phase_next     = dts_pkg::PH_HI;
                        res_next       = dts_pkg::RES_HI;
                        state_next     = dts_pkg::ST_EMIT;
                    end
                    dts_pkg::PH_HI: begin
                        cmd.cap_lsb = 1'b1;
                        phase_next  = dts_pkg::PH_START;
                        res_next    = dts_pkg::RES_SEED;
                        state_next  = dts_pkg::ST_EMIT;
                    end
                    dts_pkg::PH_START: begin
                        cmd.dist_en = 1'b1;
                        state_next  = dts_pkg::ST_PREP;
                    end
                    dts_pkg::PH_CENTER, dts_pkg::PH_DOWN: begin
                        cmd.dist_en = 1'b1;
                        state_next  = dts_pkg::ST_STORE;
                    end
                    dts_pkg::PH_UP: begin
                        cmd.dist_en = 1'b1;
                        state_next  = dts_pkg::ST_HILL;
                    end
                    default: begin
                        state_next = dts_pkg::ST_IDLE;
                    end
                endcase
            end
            dts_pkg::ST_PREP: begin
                cmd.div_load = 1'b1;
                state_next   = dts_pkg::ST_DIV;
            end
            dts_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = dts_pkg::ST_EXTRAP;
                end
            end
            dts_pkg::ST_EXTRAP: begin
                cmd.set_extrap = 1'b1;
                phase_next     = dts_pkg::PH_CENTER;
                res_next       = dts_pkg::RES_CENTER;
                state_next     = dts_pkg::ST_EMIT;
            end
            dts_pkg::ST_STORE: begin
                if (phase_reg == dts_pkg::PH_CENTER) begin
                    cmd.cap_center = 1'b1;
                    phase_next     = dts_pkg::PH_DOWN;
                    res_next       = dts_pkg::RES_DOWN;
                end else begin
                    cmd.cap_down = 1'b1;
                    phase_next   = dts_pkg::PH_UP;
                    res_next     = dts_pkg::RES_UP;
                end
                state_next = dts_pkg::ST_EMIT;
            end
            dts_pkg::ST_HILL: begin
                if (!status.any_better) begin
                    phase_next = dts_pkg::PH_IDLE;
                    res_next   = dts_pkg::RES_FINAL;
                    state_next = dts_pkg::ST_EMIT;
                end else begin
                    cmd.hill_move = 1'b1;
                    state_next    = dts_pkg::ST_CHECK;
                end
            end
            dts_pkg::ST_CHECK: begin
                if (status.iter_limit) begin
                    phase_next = dts_pkg::PH_IDLE;
                    res_next   = dts_pkg::RES_LIMIT;
                end else begin
                    phase_next = dts_pkg::PH_CENTER;
                    res_next   = dts_pkg::RES_CENTER;
                end
                state_next = dts_pkg::ST_EMIT;
            end
            dts_pkg::ST_EMIT: begin
                cmd.out_load = status.out_free;
                if (status.out_free) begin
                    state_next = dts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dts_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A sample with no sequence running produces no result
    a_idle_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == dts_pkg::OP_SAMPLE) &&
         (phase_reg == dts_pkg::PH_IDLE)) |=> (state_reg == dts_pkg::ST_IDLE))
        else $error("idle sample started work");

    // The divider stops after its last step
    a_div_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && status.div_last) |=> !cmd.div_step)
        else $error("divider stepped past its last bit");

    // A start transaction always enters the emit state on the next cycle, with the sequence restarted
    a_start_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == dts_pkg::OP_START))
        |=> (state_reg == dts_pkg::ST_EMIT) && (phase_reg == dts_pkg::PH_GND))
        else $error("start transaction did not restart the sequence");
`endif

endmodule

// File: rtl/core/dac_trim_search_core.sv
// Top level of the DAC trim search core: controller and datapath.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------------
//  s_       | in        | s_tvalid / s_tready | s_tuser: operation; s_tdata: adc_code
//  m_       | out       | m_tvalid / m_tready | m_tuser: done_res; m_tdata: request/final
//  cfg_     | in        | cfg_wr_en           | cfg_index, cfg_wdata (write only)
//
//  A start transaction goes straight to emit; a ground, code-0 or code-max sample via exec;
//  a hill-climb sample via exec and store, or hill and check; extrapolation via exec,
//  prep, restoring divider (one quotient bit per cycle, 7 bits: overflow plus 6), extrap.
//  Reset: aresetn low, synchronous; config returns to target 0, start code 15, normal mode.
//  Stalls: the result register holds a pending result while the next transaction is
//  accepted and worked on; the block waits only to load a new result into a full register.
//  A sample with no sequence running is dropped with no result.
module dac_trim_search_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [dts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dts_pkg::S_TDATA_W-1:0]  s_tdata,   // [11:0] adc_code, [15:12] zero
    input  logic                           s_tuser,   // [0] operation
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dts_pkg::M_TDATA_W-1:0]  m_tdata,   // [0] dac_write, [5:1] dac_code,
                                                      // [6] measure_channel,
                                                      // [11:7] final_code, [12] limit_hit,
                                                      // [15:13] zero
    output logic                           m_tuser    // [0] done_res
);

    // Command and status between the sequencer and the datapath
    dts_pkg::ctl_cmd_t    cmd;
    dts_pkg::ctl_status_t status;

    // Sequencer: owns the search phase and walks each transaction through the datapath
    dts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    // Datapath: readings, target distance, step divider, code selection, result register
    dts_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
